>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types for the sorted priority queue: result status codes, controller
// states, and the command and status bundles that join controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [1:0] {
    STAT_ENQUEUED  = 2'd0,
    STAT_DEQUEUED  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;    // capture the input beat and set up pointers
    logic    shift;   // move one lower-priority entry up by one slot
    logic    insert;  // write the new entry, count up
    logic    pop;     // drop the head entry, count down
    logic    report;  // load the result register
    status_t code;    // status of the reported result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic shift_go;   // entries remain to scan and the one under the scan pointer sits below the new one
    logic out_free;   // result register can take a new beat this cycle
  } dp_stat_t;

endpackage

>>> sv/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept in sorted order in a circular RAM store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat carries func, priority_req
//   and task_value. func = 0 enqueues, func = 1 dequeues the head entry.
//   Output channel (out_valid / out_stall): exactly one result beat per input
//   beat, in order: status, out_value (head value on a dequeue, else zero)
//   and occupancy after the operation.
//   Higher priority numbers leave first; equal priorities leave in arrival
//   order. A full queue drops an enqueue (overflow), an empty queue answers a
//   dequeue with underflow; neither changes the stored entries.
//   Timing: an accepted beat is captured in the load cycle; on an enqueue the
//   insertion scan then moves up every stored entry of lower priority (none
//   for a dequeue or a drop), walking back from the tail through the single
//   RAM read port and moving one entry up per cycle, before the result
//   register loads. The input is free again the cycle after the result
//   loads; the next beat is taken even while the last result waits.
//   A stalled receiver holds the result register; the controller waits until
//   it drains before loading the next result.
//   Reset (rst, synchronous) empties the queue; in_stall is high during reset.
//   The store needs no clearing pass: only data from occupied slots is used.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 4,
  parameter int VALUE_BITS    = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [PRIORITY_BITS-1:0]   priority_req,
  input  logic [VALUE_BITS-1:0]      task_value,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output spq_pkg::status_t           status,
  output logic [VALUE_BITS-1:0]      out_value,
  output logic [$clog2(DEPTH+1)-1:0] occupancy
);

  import spq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each beat: load, scan/shift or pop, then report the result.
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Hold the entries, pointers, count and the result register.
  spq_dp #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .priority_req (priority_req),
    .task_value   (task_value),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .out_value    (out_value),
    .occupancy    (occupancy)
  );

endmodule

>>> sv/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: takes one beat at a time, steps the insertion scan or the pop,
// and reports one result per beat into the datapath's result register.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             func,
  output logic             in_stall,
  output spq_pkg::dp_cmd_t cmd,
  input  spq_pkg::dp_stat_t stat
);

  import spq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = STAT_ENQUEUED;
    in_stall   = rst || (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = func ? S_DEQ : S_ENQ;
        end
      end
      S_DEQ: begin
        if (stat.out_free) begin
          cmd.report = 1'b1;
          cmd.code   = stat.empty ? STAT_UNDERFLOW : STAT_DEQUEUED;
          cmd.pop    = !stat.empty;
          state_next = S_IDLE;
        end
      end
      S_ENQ: begin
        if (stat.full) begin
          if (stat.out_free) begin
            cmd.report = 1'b1;
            cmd.code   = STAT_OVERFLOW;
            state_next = S_IDLE;
          end
        end else if (stat.shift_go) begin
          cmd.shift = 1'b1;
        end else if (stat.out_free) begin
          cmd.insert = 1'b1;
          cmd.report = 1'b1;
          cmd.code   = STAT_ENQUEUED;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: circular entry store in RAM, head/tail pointers, entry count,
// insertion scan pointers and the result register.
// ----------------------------------------------------------------------------
module spq_dp #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 4,
  parameter int VALUE_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             func,
  input  logic [PRIORITY_BITS-1:0]         priority_req,
  input  logic [VALUE_BITS-1:0]            task_value,
  input  spq_pkg::dp_cmd_t                 cmd,
  output spq_pkg::dp_stat_t                stat,
  input  logic                             out_stall,
  output logic                             out_valid,
  output spq_pkg::status_t                 status,
  output logic [VALUE_BITS-1:0]            out_value,
  output logic [$clog2(DEPTH+1)-1:0]       occupancy
);

  import spq_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int EW   = PRIORITY_BITS + VALUE_BITS;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  // control state
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // captured item and scan state
  logic [PRIORITY_BITS-1:0] item_prio;
  logic [VALUE_BITS-1:0]    item_val;
  logic [AW-1:0]            rd_ptr;
  logic [AW-1:0]            rd_ptr_next;
  logic [AW-1:0]            wr_ptr;
  logic [CW-1:0]            remain;

  // RAM
  logic          ram_we;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [PRIORITY_BITS-1:0] ram_prio;
  logic [VALUE_BITS-1:0]    ram_val;

  assign ram_prio = ram_rdata[EW-1:VALUE_BITS];
  assign ram_val  = ram_rdata[VALUE_BITS-1:0];

  always_comb begin
    rd_ptr_next = rd_ptr;
    if (cmd.load) begin
      rd_ptr_next = func ? head : ptr_dec(tail);
    end else if (cmd.shift) begin
      rd_ptr_next = ptr_dec(rd_ptr);
    end
  end

  assign ram_we    = cmd.shift || cmd.insert;
  assign ram_wdata = cmd.shift ? ram_rdata : {item_prio, item_val};

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (ram_wdata),
    .raddr (rd_ptr_next),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(DEPTH));
  assign stat.shift_go = (remain != '0) && (ram_prio < item_prio);
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.insert) begin
        tail <= ptr_inc(tail);
      end
      if (cmd.pop) begin
        head <= ptr_inc(head);
      end
      if (cmd.report) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    if (cmd.load) begin
      item_prio <= priority_req;
      item_val  <= task_value;
      wr_ptr    <= tail;
      remain    <= count;
    end else if (cmd.shift) begin
      wr_ptr <= rd_ptr;
      remain <= remain - 1'b1;
    end
    if (cmd.report) begin
      status    <= cmd.code;
      out_value <= (cmd.code == STAT_DEQUEUED) ? ram_val : '0;
      occupancy <= count_next;
    end
  end

endmodule

>>> sv/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result channel of the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input spq_pkg::status_t           status,
  input logic [VALUE_BITS-1:0]      out_value,
  input logic [$clog2(DEPTH+1)-1:0] occupancy
);

  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_value)
      && $stable(occupancy))
    else $error("stalled result beat changed");

  // only a dequeue carries a value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_DEQUEUED) |-> out_value == '0)
    else $error("nonzero value on a result other than dequeue");

  // underflow only on an empty queue
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_UNDERFLOW) |-> occupancy == '0)
    else $error("underflow reported with entries held");

  // overflow only on a full queue
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_OVERFLOW) |-> occupancy == CW'(DEPTH))
    else $error("overflow reported below full occupancy");

endmodule

bind sorted_priority_queue_core spq_checker #(
  .DEPTH      (DEPTH),
  .VALUE_BITS (VALUE_BITS)
) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .out_value (out_value),
  .occupancy (occupancy)
);
